[hdl/gaussian_weighted_state_density_sum_defines.svh]
// Assertion macros for the density accumulator.
`ifndef GAUSSIAN_WEIGHTED_STATE_DENSITY_SUM_DEFINES_SVH
`define GAUSSIAN_WEIGHTED_STATE_DENSITY_SUM_DEFINES_SVH
`ifndef SYNTHESIS
`define GWSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define GWSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define GWSD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define GWSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/gwsd_pkg.sv]
package gwsd_pkg;

	localparam int unsigned ExpTableDepthDef = 256;
	localparam logic [31:0] Log2eQ30 = 32'd1549082005;
	localparam logic [31:0] Ln2Q30 = 32'd744261118;
	localparam logic [31:0] OneQ30 = 32'd1073741824;
	localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

	// Register indexes of the configuration port.
	localparam logic [1:0] RegProbeEnergy = 2'd0;
	localparam logic [1:0] RegInvTwoSigmaSq = 2'd1;
	localparam logic [1:0] RegNormFactor = 2'd2;

	// Entry i of the 2^-(i/depth) table in Q1.30, by a truncated series for exp(-z).
	function automatic logic [30:0] exp_entry(input int unsigned i, input int unsigned depth);
		logic [63:0] z;
		logic [63:0] term;
		longint sum;
		z = (64'(i) * 64'(Ln2Q30) + 64'(depth / 2)) / 64'(depth);
		term = 64'(OneQ30);
		sum = longint'(OneQ30);
		for (int k = 1; k <= 15; k++) begin
			term = ((term * z) >> 30) / 64'(k);
			if (k % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(OneQ30)) sum = longint'(OneQ30);
		return 31'(sum);
	endfunction

	// Sequencer steps, one-hot.
	typedef enum logic [8:0] {
		ST_IDLE = 9'b000000001,
		ST_WSQR = 9'b000000010,
		ST_WSQI = 9'b000000100,
		ST_DSQ  = 9'b000001000,
		ST_PMUL = 9'b000010000,
		ST_YMUL = 9'b000100000,
		ST_GMUL = 9'b001000000,
		ST_NHI  = 9'b010000000,
		ST_NLO  = 9'b100000000
	} state_t;

	// Operand selection for the shared multiplier.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
	} mul_req_t;

endpackage

[hdl/gwsd_mul.sv]
// Shared 32x32 unsigned multiplier with registered product.
module gwsd_mul (
	input  logic                clk,
	input  gwsd_pkg::mul_req_t  req,
	output logic [63:0]         prod
);

	// One multiply per cycle, result registered.
	always_ff @(posedge clk) begin
		prod <= 64'(req.a) * 64'(req.b);
	end

endmodule

[hdl/gwsd_exp_rom.sv]
// Constant table of 2^-(i/depth), Q1.30.
module gwsd_exp_rom #(
	parameter int unsigned EXP_TABLE_DEPTH = gwsd_pkg::ExpTableDepthDef,
	localparam int unsigned IdxW = $clog2(EXP_TABLE_DEPTH)
) (
	input  logic [IdxW-1:0] idx,
	output logic [30:0]     value
);

	logic [30:0] rom [EXP_TABLE_DEPTH];

	// Table contents worked out at elaboration.
	always_comb begin
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			rom[i] = gwsd_pkg::exp_entry(i, EXP_TABLE_DEPTH);
		end
		value = rom[idx];
	end

endmodule

[hdl/gaussian_weighted_state_density_sum.sv]
// A new item is taken only once the sequencer is back in idle; all products go through
// one shared 32x32 multiplier driven by a one-hot sequencer, one multiply per step.
// An item flagged last is held off while the previous result still waits at the output.
// Reset (arst_n low) clears the sequencer, the accumulator, its saturation flag and
// output valid, and loads the configuration registers with their reset values.
`include "gaussian_weighted_state_density_sum_defines.svh"
module gaussian_weighted_state_density_sum #(
	parameter int unsigned EXP_TABLE_DEPTH = gwsd_pkg::ExpTableDepthDef
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] u_real,
	input  logic signed [15:0] u_imag,
	input  logic signed [23:0] eig_energy,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [47:0]        density,
	output logic               overflow,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	localparam int unsigned IdxW = $clog2(EXP_TABLE_DEPTH);

	gwsd_pkg::state_t state_q;
	logic signed [23:0] probe_q;
	logic [31:0] inv_q, norm_q;
	logic [15:0] ur_q, ui_q;
	logic [24:0] dmag_q;
	logic last_q;
	logic [31:0] weight_q;
	logic big_q;
	logic [47:0] sum_q;
	logic sat_q;
	logic [47:0] dens_q;
	logic [47:0] hipart_q;
	logic out_valid_q, out_ovf_q;

	gwsd_pkg::mul_req_t req;
	logic [63:0] prod;
	logic [30:0] tab_val;
	logic [IdxW-1:0] tab_idx;
	logic [15:0] ur_abs, ui_abs;
	logic signed [24:0] diff;
	logic [47:0] contrib;
	logic [48:0] sum_next;
	logic [47:0] sum_sat;
	logic [4:0] y_int;
	logic [15:0] y_frac;
	logic [30:0] gauss;

	gwsd_mul u_mul (.clk(clk), .req(req), .prod(prod));
	gwsd_exp_rom #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_rom (.idx(tab_idx), .value(tab_val));

	// Magnitudes of the operands.
	assign ur_abs = ur_q[15] ? 16'(-ur_q) : ur_q;
	assign ui_abs = ui_q[15] ? 16'(-ui_q) : ui_q;
	assign diff = 25'(probe_q) - 25'(eig_energy);

	// Exponent split of y = (a*log2e)>>30 taken from the product in step YMUL result.
	assign y_int = prod[50:46];
	assign y_frac = prod[45:30];
	assign tab_idx = IdxW'((32'(y_frac) * EXP_TABLE_DEPTH) >> 16);

	// Gaussian from the table, shifted by the integer part of the exponent.
	assign gauss = big_q ? '0 : (tab_val >> y_int);

	// Operand selection for the shared multiplier.
	always_comb begin
		req = '0;
		case (state_q)
			gwsd_pkg::ST_WSQR: req = '{a: 32'(ur_abs), b: 32'(ur_abs)};
			gwsd_pkg::ST_WSQI: req = '{a: 32'(ui_abs), b: 32'(ui_abs)};
			gwsd_pkg::ST_DSQ:  req = '{a: 32'(dmag_q), b: 32'(dmag_q)};
			gwsd_pkg::ST_PMUL: req = '{a: prod[47:16], b: inv_q};
			gwsd_pkg::ST_YMUL: req = '{a: prod[47:16], b: gwsd_pkg::Log2eQ30};
			gwsd_pkg::ST_GMUL: req = '{a: weight_q, b: 32'(gauss)};
			gwsd_pkg::ST_NHI:  req = '{a: 32'(sum_sat[47:32]), b: norm_q};
			gwsd_pkg::ST_NLO:  req = '{a: sum_q[31:0], b: norm_q};
			default:           req = '0;
		endcase
	end

	// Saturating sum of the accumulator and the new contribution.
	assign contrib = 48'(prod >> 28);
	assign sum_next = 49'(sum_q) + 49'(contrib);
	assign sum_sat = (sum_next > 49'(gwsd_pkg::Mask48)) ? gwsd_pkg::Mask48 : sum_next[47:0];

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
			inv_q <= 32'd65536;
			norm_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				gwsd_pkg::RegProbeEnergy:   probe_q <= cfg_data[23:0];
				gwsd_pkg::RegInvTwoSigmaSq: inv_q <= cfg_data;
				gwsd_pkg::RegNormFactor:    norm_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = (state_q != gwsd_pkg::ST_IDLE) || (out_valid_q && last);

	// Sequencer and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gwsd_pkg::ST_IDLE;
			sum_q <= '0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_ovf_q <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				gwsd_pkg::ST_IDLE: begin
					if (in_valid && !in_stall) state_q <= gwsd_pkg::ST_WSQR;
				end
				gwsd_pkg::ST_WSQR: state_q <= gwsd_pkg::ST_WSQI;
				gwsd_pkg::ST_WSQI: state_q <= gwsd_pkg::ST_DSQ;
				gwsd_pkg::ST_DSQ:  state_q <= gwsd_pkg::ST_PMUL;
				gwsd_pkg::ST_PMUL: state_q <= gwsd_pkg::ST_YMUL;
				gwsd_pkg::ST_YMUL: state_q <= gwsd_pkg::ST_GMUL;
				gwsd_pkg::ST_GMUL: state_q <= gwsd_pkg::ST_NHI;
				gwsd_pkg::ST_NHI: begin
					// Weighted Gaussian product is on prod now.
					sum_q <= sum_sat;
					if (sum_next > 49'(gwsd_pkg::Mask48)) sat_q <= 1'b1;
					state_q <= last_q ? gwsd_pkg::ST_NLO : gwsd_pkg::ST_IDLE;
				end
				gwsd_pkg::ST_NLO: begin
					state_q <= gwsd_pkg::ST_IDLE;
					out_valid_q <= 1'b1;
					out_ovf_q <= sat_q;
					sum_q <= '0;
					sat_q <= 1'b0;
				end
				default: state_q <= gwsd_pkg::ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			gwsd_pkg::ST_IDLE: begin
				ur_q <= u_real;
				ui_q <= u_imag;
				last_q <= last;
				dmag_q <= diff[24] ? 25'(-diff) : 25'(diff);
			end
			gwsd_pkg::ST_WSQI: weight_q <= prod[31:0];
			gwsd_pkg::ST_DSQ:  weight_q <= weight_q + prod[31:0];
			gwsd_pkg::ST_YMUL: begin
				// p >= 16<<32 means the Gaussian is zero.
				big_q <= (prod[63:36] != '0);
			end
			gwsd_pkg::ST_NLO: hipart_q <= 48'(prod);
			default: ;
		endcase
	end

	// Normalized result: hi*norm + (lo*norm)>>32, taken in the cycle after NLO.
	logic fin_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) fin_q <= 1'b0;
		else fin_q <= (state_q == gwsd_pkg::ST_NLO);
	end
	always_ff @(posedge clk) begin
		if (fin_q) dens_q <= hipart_q + 48'(prod[63:32]);
	end

	assign out_valid = out_valid_q && !fin_q;
	assign density = dens_q;
	assign overflow = out_ovf_q;

	`GWSD_ASSERT_IMP(a_busy_stalls, clk, arst_n, state_q != gwsd_pkg::ST_IDLE, in_stall)
	`GWSD_ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(state_q))
	`GWSD_ASSERT_NEXT(a_clear_after, clk, arst_n, state_q == gwsd_pkg::ST_NLO, sum_q == '0 && !sat_q)

endmodule
